/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants for the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

   // parse phases, one-hot
   typedef enum logic [4:0] {
      PH_HDR0 = 5'b00001,
      PH_HDR1 = 5'b00010,
      PH_XLEN = 5'b00100,
      PH_MASK = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   // opcodes with a meaning of their own
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // header field masks and length escape codes
   localparam logic [7:0] HDR_TOP_BIT   = 8'h80;
   localparam logic [7:0] HDR_OPC_MASK  = 8'h0F;
   localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;
   localparam logic [6:0] LEN_CODE_16   = 7'd126;
   localparam logic [6:0] LEN_CODE_64   = 7'd127;

   // extended length bytes still due after the first
   localparam logic [2:0] XLEN_LEFT_16  = 3'd1;
   localparam logic [2:0] XLEN_LEFT_64  = 3'd7;

   localparam logic [1:0] MASK_POS_LAST = 2'd3;

   // one result item
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic [3:0] message_type;
      logic       is_control;
      logic       end_of_message;
      logic       message_restart;
      logic       frame_was_masked;
   } result_type;

   function automatic logic is_ctrl_op(input logic [3:0] op);
      return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage

/* rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// frame header parser, mask key capture and payload unmask, one byte per step
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type   parse_phase_ff, parse_phase_in;
   logic        frame_fin_ff, frame_fin_in;
   logic [3:0]  frame_opcode_ff, frame_opcode_in;
   logic        frame_masked_ff, frame_masked_in;
   logic [63:0] remaining_length_ff, remaining_length_in;
   logic [2:0]  length_bytes_left_ff, length_bytes_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_position_ff, mask_position_in;
   logic        message_open_ff, message_open_in;
   logic [3:0]  open_message_type_ff, open_message_type_in;
   logic        restart_pending_ff, restart_pending_in;

   logic        hdr_done;
   logic        last;
   logic        ctrl;
   logic [6:0]  len7;
   logic [7:0]  key_byte;
   logic [7:0]  data_byte;

   always_comb begin
      parse_phase_in       = parse_phase_ff;
      frame_fin_in         = frame_fin_ff;
      frame_opcode_in      = frame_opcode_ff;
      frame_masked_in      = frame_masked_ff;
      remaining_length_in  = remaining_length_ff;
      length_bytes_left_in = length_bytes_left_ff;
      mask_key_in          = mask_key_ff;
      mask_position_in     = mask_position_ff;
      message_open_in      = message_open_ff;
      open_message_type_in = open_message_type_ff;
      restart_pending_in   = restart_pending_ff;
      hdr_done             = 1'b0;
      res_valid            = 1'b0;
      res                  = '0;

      len7      = 7'(rx_byte & HDR_LEN_MASK);
      ctrl      = is_ctrl_op(frame_opcode_ff);
      last      = (remaining_length_ff == 64'd1);
      case (mask_position_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
      data_byte = frame_masked_ff ? (rx_byte ^ key_byte) : rx_byte;

      case (parse_phase_ff)
         PH_HDR0: begin
            frame_fin_in    = (rx_byte & HDR_TOP_BIT) != 8'd0;
            frame_opcode_in = 4'(rx_byte & HDR_OPC_MASK);
            parse_phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            frame_masked_in  = (rx_byte & HDR_TOP_BIT) != 8'd0;
            mask_position_in = '0;
            if ((len7 == LEN_CODE_16) || (len7 == LEN_CODE_64)) begin
               remaining_length_in  = '0;
               length_bytes_left_in = (len7 == LEN_CODE_16) ? XLEN_LEFT_16 : XLEN_LEFT_64;
               parse_phase_in       = PH_XLEN;
            end else begin
               remaining_length_in = 64'(len7);
               if (frame_masked_in) begin
                  parse_phase_in = PH_MASK;
               end else begin
                  hdr_done = 1'b1;
               end
            end
         end
         PH_XLEN: begin
            remaining_length_in = {remaining_length_ff[55:0], rx_byte};
            if (length_bytes_left_ff != 3'd0) begin
               length_bytes_left_in = length_bytes_left_ff - 3'd1;
            end else if (frame_masked_ff) begin
               parse_phase_in = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end
         PH_MASK: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            if (mask_position_ff != MASK_POS_LAST) begin
               mask_position_in = mask_position_ff + 2'd1;
            end else begin
               hdr_done = 1'b1;
            end
         end
         PH_DATA: begin
            mask_position_in    = mask_position_ff + 2'd1;
            remaining_length_in = remaining_length_ff - 64'd1;
            if (last) begin
               parse_phase_in = PH_HDR0;
            end
            if (ctrl) begin
               res_valid          = 1'b1;
               res.payload_byte   = data_byte;
               res.has_byte       = 1'b1;
               res.message_type   = frame_opcode_ff;
               res.is_control     = 1'b1;
               res.end_of_message = last;
            end else if (message_open_ff) begin
               res_valid           = 1'b1;
               res.payload_byte    = data_byte;
               res.has_byte        = 1'b1;
               res.message_type    = open_message_type_ff;
               res.end_of_message  = last && frame_fin_ff;
               res.message_restart = restart_pending_ff;
               restart_pending_in  = 1'b0;
               if (last && frame_fin_ff) begin
                  message_open_in = 1'b0;
               end
            end
         end
         default: begin
            parse_phase_in = PH_HDR0;
         end
      endcase

      // header complete: open data messages, handle empty frames
      if (hdr_done) begin
         mask_position_in = '0;
         if (!ctrl && (frame_opcode_ff != OP_CONT)) begin
            if (message_open_ff) begin
               restart_pending_in = 1'b1;
            end
            message_open_in      = 1'b1;
            open_message_type_in = frame_opcode_ff;
         end
         if (remaining_length_in != 64'd0) begin
            parse_phase_in = PH_DATA;
         end else begin
            parse_phase_in = PH_HDR0;
            if (ctrl) begin
               res_valid          = 1'b1;
               res.message_type   = frame_opcode_ff;
               res.is_control     = 1'b1;
               res.end_of_message = 1'b1;
            end else if (message_open_in && frame_fin_ff) begin
               res_valid           = 1'b1;
               res.message_type    = open_message_type_in;
               res.end_of_message  = 1'b1;
               res.message_restart = restart_pending_in;
               restart_pending_in  = 1'b0;
               message_open_in     = 1'b0;
            end
         end
      end

      res.frame_was_masked = frame_masked_in;
      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff       <= PH_HDR0;
         frame_fin_ff         <= 1'b0;
         frame_opcode_ff      <= '0;
         frame_masked_ff      <= 1'b0;
         remaining_length_ff  <= '0;
         length_bytes_left_ff <= '0;
         mask_key_ff          <= '0;
         mask_position_ff     <= '0;
         message_open_ff      <= 1'b0;
         open_message_type_ff <= '0;
         restart_pending_ff   <= 1'b0;
      end else if (step) begin
         parse_phase_ff       <= parse_phase_in;
         frame_fin_ff         <= frame_fin_in;
         frame_opcode_ff      <= frame_opcode_in;
         frame_masked_ff      <= frame_masked_in;
         remaining_length_ff  <= remaining_length_in;
         length_bytes_left_ff <= length_bytes_left_in;
         mask_key_ff          <= mask_key_in;
         mask_position_ff     <= mask_position_in;
         message_open_ff      <= message_open_in;
         open_message_type_ff <= open_message_type_in;
         restart_pending_ff   <= restart_pending_in;
      end
   end

endmodule

/* rtl/wsd_rsp_stage.sv */
// ----------------------------------------------------------------------------
// wsd_rsp_stage
// result register holding one item until the consumer takes it
// ----------------------------------------------------------------------------
module wsd_rsp_stage import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// streaming websocket frame decoder: header parse, unmask, message tagging
// ----------------------------------------------------------------------------
// Takes one received stream byte per item and sustains one item per clock
// while the consumer does not stall. Each byte lands in an input register,
// passes through the header/unmask logic, and any result it causes is written
// to the result register. Header, extended length and mask key bytes produce
// no result; payload bytes produce one unmasked byte each, and empty control
// frames or empty final fragments produce a single empty end marker. Orphan
// continuation bytes are dropped.
// The input side stalls only while the input register is full and the result
// register holds an item the consumer is stalling; the 64-bit length counter
// decrement and its compare set the cycle time.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic [3:0] rsp_message_type,
   output logic       rsp_is_control,
   output logic       rsp_end_of_message,
   output logic       rsp_message_restart,
   output logic       rsp_frame_was_masked
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;

   // byte moves from the input register through the parser
   logic       advance;
   logic       req_take;

   logic       res_valid;
   result_type res;
   result_type rsp_data;

   // parser may run whenever the result register has room this cycle
   assign advance   = in_vld_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // header parse and payload unmask
   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register
   wsd_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_payload_byte     = rsp_data.payload_byte;
   assign rsp_has_byte         = rsp_data.has_byte;
   assign rsp_message_type     = rsp_data.message_type;
   assign rsp_is_control       = rsp_data.is_control;
   assign rsp_end_of_message   = rsp_data.end_of_message;
   assign rsp_message_restart  = rsp_data.message_restart;
   assign rsp_frame_was_masked = rsp_data.frame_was_masked;

   // an empty marker always closes a message and carries no byte
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_end_of_message && (rsp_payload_byte == 8'd0)))
      else $error("empty marker without end of message or with a byte");

   // control items never report a restart and always carry a control opcode
   a_ctrl_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_control) |-> (!rsp_message_restart &&
         (rsp_message_type == OP_CLOSE || rsp_message_type == OP_PING ||
          rsp_message_type == OP_PONG)))
      else $error("bad control result");

   // a held input byte is not lost while the result side is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("input register dropped a waiting byte");

   // a result is only produced when the result register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule
